// File: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Request codes, cell commands and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int POS_W     = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_READ   = 3'd3,
    OP_WRITE  = 3'd4,
    OP_FIND   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_WRITE,
    CMD_INSERT,
    CMD_DELETE
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [POS_W-1:0]         found_at;
    logic [POS_W-1:0]         list_length;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/pls_req_if.sv
// ----------------------------------------------------------------------------
// pls_req_if: request channel of the positional list store
// Valid/ready handshake carrying one request beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pls_req_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_value;

  modport source (output valid, op, position, data_value, input ready);
  modport sink   (input valid, op, position, data_value, output ready);
endinterface

`default_nettype wire

// File: rtl/pls_rsp_if.sv
// ----------------------------------------------------------------------------
// pls_rsp_if: result channel of the positional list store
// Valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pls_rsp_if import pls_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_value;
  logic [POS_W-1:0]         found_at;
  logic [POS_W-1:0]         list_length;

  modport source (output valid, ok, read_value, found_at, list_length, input ready);
  modport sink   (input valid, ok, read_value, found_at, list_length, output ready);
endinterface

`default_nettype wire

// File: rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell: one list entry of the cell chain
// Holds one entry, shifts with its neighbours on insert and delete, and
// passes the read/find probe on to the next cell each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_cell import pls_pkg::*; #(
  parameter int IDX = 0,
  parameter int IXW = 6,
  parameter int IW  = 7
) (
  input  wire logic              clk_i,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [IXW-1:0]    at_i,
  input  wire logic [IW-1:0]     count_i,
  input  wire logic [DATA_W-1:0] key_i,
  input  wire logic [DATA_W-1:0] left_i,
  input  wire logic [DATA_W-1:0] right_i,
  input  wire logic [IW-1:0]     found_i,
  input  wire logic [DATA_W-1:0] rd_i,
  output      logic [DATA_W-1:0] entry_o,
  output      logic [IW-1:0]     found_o,
  output      logic [DATA_W-1:0] rd_o
);

  localparam logic [IXW-1:0] MY_IX    = IXW'(IDX);
  localparam logic [IW-1:0]  MY_IX_W  = IW'(IDX);
  localparam logic [IW-1:0]  MY_POS_W = IW'(IDX + 1);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic [IW-1:0]     found_q, found_d;
  logic [DATA_W-1:0] rd_q, rd_d;

  always_comb begin
    entry_d = entry_q;
    case (ctl_i.cmd)
      CMD_WRITE: begin
        if (at_i == MY_IX) entry_d = ctl_i.value;
      end
      CMD_INSERT: begin
        if (at_i == MY_IX) entry_d = ctl_i.value;
        else if (MY_IX > at_i) entry_d = left_i;
      end
      CMD_DELETE: begin
        if (MY_IX >= at_i) entry_d = right_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // keep the first match seen upstream
  always_comb begin
    found_d = found_i;
    if (found_i == '0 && MY_IX_W < count_i && entry_q == key_i) found_d = MY_POS_W;
    rd_d = (at_i == MY_IX) ? entry_q : rd_i;
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    found_q <= found_d;
    rd_q    <= rd_d;
  end

  assign entry_o = entry_q;
  assign found_o = found_q;
  assign rd_o    = rd_q;

endmodule

`default_nettype wire

// File: rtl/positional_list_store_unit.sv
// ----------------------------------------------------------------------------
// positional_list_store_unit: bounded ordered list with 1-based positions
// Append, insert, delete, read, overwrite and find on a chain of cells.
// ----------------------------------------------------------------------------
// Each list entry lives in its own cell; insert, delete, append and overwrite
// act on all cells at once, so those requests (and any request that fails its
// position or fullness check, or carries an unknown op) produce their result in
// the cycle of acceptance. Read and find send a probe down the chain one cell
// per cycle, so a successful read or any find produces its result once the
// probe has left the last cell. One request is in the block at a time; a
// finished result waits in the output register while the next request is
// accepted, and a second result waits in a holding register until the output
// register drains. list_length and found_at are 7 bits wide.
`default_nettype none

module positional_list_store_unit import pls_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pls_req_if.sink    req_i,
  pls_rsp_if.source  rsp_o
);

  localparam int IW  = $clog2(DEPTH + 1);
  localparam int IXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = (IW > POS_W) ? IW + 1 : POS_W + 1;
  localparam logic [IW-1:0] DEPTH_C = IW'(DEPTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [IW-1:0]     count_q, count_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic [IXW-1:0]    idx_q;
  logic [DATA_W-1:0] key_q;
  logic              find_q;
  rsp_t              res_q, out_q;
  logic              out_valid_q, out_valid_d;

  logic              fire, out_free, sweep_now;
  logic [CW-1:0]     pos_x, cnt_x;
  logic              in_range, ins_range, not_full;
  logic [IXW-1:0]    p0, at_now, at_sel;
  cell_ctl_t         ctl;
  logic [IW-1:0]     count_next;
  rsp_t              res_imm, res_swp, res_sel;
  logic              produce, load_out;

  logic [DATA_W-1:0] entry [DEPTH];
  logic [IW-1:0]     found [DEPTH+1];
  logic [DATA_W-1:0] rd    [DEPTH+1];

  assign fire     = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  assign pos_x     = CW'(req_i.position);
  assign cnt_x     = CW'(count_q);
  assign in_range  = (pos_x != '0) && (pos_x <= cnt_x);
  assign ins_range = (pos_x != '0) && (pos_x <= cnt_x + CW'(1));
  assign not_full  = (count_q != DEPTH_C);
  assign p0        = IXW'(pos_x - CW'(1));

  // decode the accepted request
  always_comb begin
    ctl.cmd    = CMD_HOLD;
    ctl.value  = req_i.data_value;
    at_now     = p0;
    count_next = count_q;
    sweep_now  = 1'b0;
    res_imm    = '0;
    case (req_i.op)
      OP_APPEND: begin
        at_now = IXW'(count_q);
        if (not_full) begin
          ctl.cmd     = CMD_WRITE;
          count_next  = count_q + IW'(1);
          res_imm.ok  = 1'b1;
        end
      end
      OP_INSERT: begin
        if (not_full && ins_range) begin
          ctl.cmd     = CMD_INSERT;
          count_next  = count_q + IW'(1);
          res_imm.ok  = 1'b1;
        end
      end
      OP_DELETE: begin
        if (in_range) begin
          ctl.cmd     = CMD_DELETE;
          count_next  = count_q - IW'(1);
          res_imm.ok  = 1'b1;
        end
      end
      OP_READ: begin
        if (in_range) sweep_now = 1'b1;
      end
      OP_WRITE: begin
        if (in_range) begin
          ctl.cmd     = CMD_WRITE;
          res_imm.ok  = 1'b1;
        end
      end
      OP_FIND: sweep_now = 1'b1;
      default: sweep_now = 1'b0;
    endcase
    if (!fire) begin
      ctl.cmd    = CMD_HOLD;
      count_next = count_q;
    end
    res_imm.list_length = POS_W'(count_next);
  end

  assign at_sel = (state_q == ST_IDLE) ? at_now : idx_q;

  always_comb begin
    res_swp             = '0;
    res_swp.ok          = 1'b1;
    res_swp.read_value  = find_q ? '0 : rd[DEPTH];
    res_swp.found_at    = find_q ? POS_W'(found[DEPTH]) : '0;
    res_swp.list_length = POS_W'(count_q);
  end

  // result producer and output staging
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    produce = 1'b0;
    res_sel = res_imm;
    case (state_q)
      ST_IDLE: begin
        if (fire) begin
          if (sweep_now) begin
            state_d = ST_SWEEP;
            cnt_d   = '0;
          end else begin
            produce = 1'b1;
          end
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == DEPTH_C) begin
          produce = 1'b1;
          res_sel = res_swp;
          state_d = ST_IDLE;
        end
      end
      ST_PUSH: begin
        res_sel = res_q;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (produce && !out_free) state_d = ST_PUSH;
  end

  assign load_out    = (produce || state_q == ST_PUSH) && out_free;
  assign out_valid_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign count_d = count_next;

  always_ff @(posedge clk_i) begin
    if (fire) begin
      idx_q  <= p0;
      key_q  <= req_i.data_value;
      find_q <= (req_i.op == OP_FIND);
    end
    if (produce && !out_free) res_q <= res_sel;
    if (load_out) out_q <= res_sel;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_q.ok;
  assign rsp_o.read_value  = out_q.read_value;
  assign rsp_o.found_at    = out_q.found_at;
  assign rsp_o.list_length = out_q.list_length;

  // cell chain
  assign found[0] = '0;
  assign rd[0]    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = entry[i];
    end else begin : g_mid
      assign left_w = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry[i];
    end else begin : g_inner
      assign right_w = entry[i+1];
    end

    pls_cell #(
      .IDX (i),
      .IXW (IXW),
      .IW  (IW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .at_i    (at_sel),
      .count_i (count_q),
      .key_i   (key_q),
      .left_i  (left_w),
      .right_i (right_w),
      .found_i (found[i]),
      .rd_i    (rd[i]),
      .entry_o (entry[i]),
      .found_o (found[i+1]),
      .rd_o    (rd[i+1])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("list length beyond capacity");

  a_push_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> out_valid_q)
    else $error("held result without a busy output register");

  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(req_i.valid && req_i.ready))
    else $error("list length changed without an accepted beat");

  a_sweep_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |=> $stable(count_q))
    else $error("list length changed during a probe sweep");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for positional_list_store_unit
// Replays list requests through the request channel and checks every result
// beat against an in-bench list predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import pls_pkg::*;

  localparam int LIST_DEPTH  = DEPTH_DEF;
  localparam int TOTAL_ITEMS = 1975;
  localparam int CYCLE_LIMIT = 1_000_000;

  // unused request codes: the block must refuse them
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef enum logic [1:0] {
    BURST_GROW,
    BURST_SHRINK,
    BURST_MIXED,
    BURST_NOISE
  } burst_e;

  typedef struct packed {
    logic [LIST_DEPTH-1:0][DATA_W-1:0] cells;
    logic [POS_W-1:0]                  count;
  } list_t;

  typedef struct packed {
    list_t lst;
    rsp_t  rsp;
  } step_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_value;
    logic [2:0]        gap;
  } req_item_t;

  logic clk;
  logic rst_n;

  pls_req_if req_if ();
  pls_rsp_if rsp_if ();

  positional_list_store_unit #(
    .DEPTH (LIST_DEPTH)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_item_t   request_q[$];
  rsp_t        result_q[$];
  list_t       plan;
  list_t       live;
  logic        quiet_burst;
  int unsigned queued;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  logic [2:0]  idle_cnt;
  logic [2:0]  rsp_wait;
  logic        rsp_calm;

  // Apply one request to a list and give the list afterwards and the result.
  function automatic step_t apply_request(input list_t lst, input logic [OP_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic [DATA_W-1:0] val);
    step_t s;
    int    n;
    int    p;
    int    i;
    s     = '0;
    s.lst = lst;
    n     = int'(lst.count);
    p     = int'(pos);
    case (op)
      OP_APPEND: begin
        if (n < LIST_DEPTH) begin
          s.lst.cells[n] = val;
          s.lst.count    = POS_W'(n + 1);
          s.rsp.ok       = 1'b1;
        end
      end
      OP_INSERT: begin
        if (n < LIST_DEPTH && p >= 1 && p <= n + 1) begin
          for (i = n; i >= p; i--) s.lst.cells[i] = s.lst.cells[i-1];
          s.lst.cells[p-1] = val;
          s.lst.count      = POS_W'(n + 1);
          s.rsp.ok         = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= n) begin
          for (i = p; i < n; i++) s.lst.cells[i-1] = s.lst.cells[i];
          s.lst.count = POS_W'(n - 1);
          s.rsp.ok    = 1'b1;
        end
      end
      OP_READ: begin
        if (p >= 1 && p <= n) begin
          s.rsp.read_value = lst.cells[p-1];
          s.rsp.ok         = 1'b1;
        end
      end
      OP_WRITE: begin
        if (p >= 1 && p <= n) begin
          s.lst.cells[p-1] = val;
          s.rsp.ok         = 1'b1;
        end
      end
      OP_FIND: begin
        // first match wins
        for (i = n - 1; i >= 0; i--) begin
          if (lst.cells[i] == val) s.rsp.found_at = POS_W'(i + 1);
        end
        s.rsp.ok = 1'b1;
      end
      default: ;
    endcase
    s.rsp.list_length = s.lst.count;
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1:    return DATA_W'($urandom_range(0, 7)) - 32'd3;  // small: duplicates
      2:       return 32'h8000_0000;
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position up to last; now and then one outside it.
  function automatic int unsigned pick_position(input int unsigned last);
    if (last == 0 || $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) != 0 && last < 127) return $urandom_range(last + 1, 127);
      return 0;
    end
    return $urandom_range(1, last);
  endfunction

  // Mostly a value already in the list, so that find hits.
  function automatic logic [DATA_W-1:0] pick_target();
    if (plan.count != 0 && $urandom_range(0, 4) < 3)
      return plan.cells[$urandom_range(0, plan.count - 1)];
    return pick_value();
  endfunction

  task automatic push_request(input logic [OP_W-1:0] op, input int unsigned pos,
                              input logic [DATA_W-1:0] val);
    req_item_t it;
    step_t     s;
    it.op         = op;
    it.position   = pos[POS_W-1:0];
    it.data_value = val;
    it.gap        = quiet_burst ? 3'd0 : 3'($urandom_range(0, 4));
    s             = apply_request(plan, it.op, it.position, it.data_value);
    plan          = s.lst;
    request_q.push_back(it);
    queued++;
  endtask

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("positional_list_store_unit test failed");
      $finish;
    end
  end

  always @(posedge clk or negedge rst_n) begin : request_driver
    req_item_t nxt;
    step_t     s;
    if (!rst_n) begin
      req_if.valid      <= 1'b0;
      req_if.op         <= '0;
      req_if.position   <= '0;
      req_if.data_value <= '0;
      idle_cnt          <= '0;
      live = '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        s    = apply_request(live, req_if.op, req_if.position, req_if.data_value);
        live = s.lst;
        result_q.push_back(s.rsp);
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (idle_cnt < request_q[0].gap) begin
          req_if.valid <= 1'b0;
          idle_cnt     <= idle_cnt + 3'd1;
        end else begin
          nxt = request_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.op         <= nxt.op;
          req_if.position   <= nxt.position;
          req_if.data_value <= nxt.data_value;
          idle_cnt          <= '0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin : result_monitor
    rsp_t       want;
    logic [2:0] stall;
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_wait     <= '0;
      rsp_calm     <= 1'b0;
    end else begin
      stall = rsp_wait;
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no request outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("ok", DATA_W'(want.ok), DATA_W'(rsp_if.ok));
          check_field("read_value", want.read_value, rsp_if.read_value);
          check_field("found_at", DATA_W'(want.found_at), DATA_W'(rsp_if.found_at));
          check_field("list_length", DATA_W'(want.list_length), DATA_W'(rsp_if.list_length));
        end
        stall = rsp_calm ? 3'd0 : 3'($urandom_range(0, 4));
      end else if (stall == 0 && !rsp_calm && $urandom_range(0, 7) == 0) begin
        // drop ready now and then between result beats
        stall = 3'($urandom_range(1, 4));
      end
      if ($urandom_range(0, 99) == 0) rsp_calm <= !rsp_calm;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_wait     <= stall - 3'd1;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_wait     <= '0;
      end
    end
  end

  initial begin
    burst_e kind;
    int     len;
    int     roll;
    int     k;

    clk               = 1'b0;
    rst_n             = 1'b0;
    queued            = 0;
    plan              = '0;

    // directed: empty list, position edges, extremes of value, every op
    quiet_burst = 1'b0;
    push_request(OP_READ,   1,   32'h0);
    push_request(OP_DELETE, 1,   32'h0);
    push_request(OP_FIND,   0,   32'h0);
    push_request(OP_INSERT, 0,   32'h1234_5678);
    push_request(OP_INSERT, 2,   32'h1234_5678);
    push_request(OP_INSERT, 1,   32'h8000_0000);
    push_request(OP_APPEND, 127, 32'h7FFF_FFFF);
    push_request(OP_INSERT, 3,   32'hFFFF_FFFF);
    push_request(OP_INSERT, 2,   32'h0000_0001);
    push_request(OP_READ,   1,   32'h0);
    push_request(OP_READ,   4,   32'h0);
    push_request(OP_READ,   5,   32'h0);
    push_request(OP_READ,   127, 32'hFFFF_FFFF);
    push_request(OP_WRITE,  4,   32'h5555_5555);
    push_request(OP_WRITE,  0,   32'hAAAA_AAAA);
    push_request(OP_FIND,   0,   32'h7FFF_FFFF);
    push_request(OP_FIND,   127, 32'd42);
    push_request(OP_RSVD_6, 1,   32'hFFFF_FFFF);
    push_request(OP_RSVD_7, 127, 32'hFFFF_FFFF);
    push_request(OP_DELETE, 1,   32'h0);
    push_request(OP_DELETE, 4,   32'h0);
    push_request(OP_DELETE, 3,   32'h0);
    push_request(OP_READ,   2,   32'h0);

    // fill past full so that refused appends and inserts appear early
    quiet_burst = 1'b1;
    for (k = 0; k < 75; k++) begin
      if ($urandom_range(0, 1) != 0) push_request(OP_APPEND, $urandom_range(0, 127), pick_value());
      else push_request(OP_INSERT, pick_position(plan.count + 1), pick_value());
    end

    while (queued < TOTAL_ITEMS) begin
      roll = $urandom_range(0, 99);
      kind = roll < 30 ? BURST_GROW : roll < 55 ? BURST_SHRINK :
             roll < 85 ? BURST_MIXED : BURST_NOISE;
      len  = $urandom_range(5, 60);
      quiet_burst = ($urandom_range(0, 3) == 0);
      for (k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        case (kind)
          BURST_GROW: begin
            if (roll < 50) push_request(OP_APPEND, $urandom_range(0, 127), pick_value());
            else if (roll < 95) push_request(OP_INSERT, pick_position(plan.count + 1), pick_value());
            else push_request(OP_READ, pick_position(plan.count), pick_value());
          end
          BURST_SHRINK: begin
            if (roll < 65) push_request(OP_DELETE, pick_position(plan.count), pick_value());
            else if (roll < 85) push_request(OP_READ, pick_position(plan.count), pick_value());
            else push_request(OP_FIND, $urandom_range(0, 127), pick_target());
          end
          BURST_MIXED: begin
            case (roll % 6)
              0: push_request(OP_APPEND, $urandom_range(0, 127), pick_value());
              1: push_request(OP_INSERT, pick_position(plan.count + 1), pick_value());
              2: push_request(OP_DELETE, pick_position(plan.count), pick_value());
              3: push_request(OP_READ, pick_position(plan.count), pick_value());
              4: push_request(OP_WRITE, pick_position(plan.count), pick_value());
              default: push_request(OP_FIND, $urandom_range(0, 127), pick_target());
            endcase
          end
          default: begin
            push_request(OP_W'($urandom_range(0, 7)), $urandom_range(0, 127), pick_value());
          end
        endcase
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every request taken and every result seen
    while (request_q.size() != 0 || req_if.valid || result_q.size() != 0) @(posedge clk);
    repeat (LIST_DEPTH + 8) @(posedge clk);

    if (errors == 0) begin
      $display("positional_list_store_unit test passed");
    end else begin
      $display("positional_list_store_unit test failed");
    end
    $finish;
  end

endmodule
